@@ rtl/core/seel_pkg.sv @@
`timescale 1ns / 1ps

package seel_pkg;

  localparam int RING_DEPTH   = 64;
  localparam int DOMAIN_COUNT = 8;

  localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int COUNT_W  = $clog2(RING_DEPTH + 1);
  localparam int IDX_W    = 6;
  localparam int CMP_W    = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;
  localparam int DIDX_W   = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1;

  localparam logic [4:0] DOM_LIMIT = 5'(DOMAIN_COUNT);
  localparam logic [3:0] SEV_NONE  = 4'd0;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef logic [6:0] retained_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [3:0]         domain;
    logic [3:0]         severity;
    logic [31:0]        time_sec;
    logic [IDX_W-1:0]   read_index;
  } in_t;

  typedef struct packed {
    logic               edge_recorded;
    logic               entry_valid;
    logic [31:0]        event_time;
    logic [2:0]         event_domain;
    logic [3:0]         event_from;
    logic [3:0]         event_to;
    retained_t          retained_count;
    logic [31:0]        total_events;
  } out_t;

  typedef struct packed {
    logic [31:0] time_sec;
    logic [3:0]  domain;
    logic [3:0]  from_level;
    logic [3:0]  to_level;
  } entry_t;

endpackage

@@ rtl/core/severity_edge_event_log.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Beat type        Handshake
// in       input      seel_pkg::in_t   in_valid / in_ready
// out      output     seel_pkg::out_t  out_valid / out_ready
//
// One item per cycle sustained while the output is not stalled. An item
// waits in the holding stage, then moves to the output register; the ring
// memory read is registered, so every item passes one holding stage first.
// Synchronous reset (rst) and the clear opcode empty the log and domain table
// at once; ring contents are not cleared, the held count gates all reads.
// A stalled output holds the holding stage; input is taken while the output
// waits as long as the holding stage can move or is empty.

module severity_edge_event_log (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  seel_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output seel_pkg::out_t  out_data
);

  localparam int AW     = seel_pkg::RING_AW;
  localparam int CW     = seel_pkg::COUNT_W;
  localparam int PW     = seel_pkg::CMP_W;
  localparam int DW     = seel_pkg::DIDX_W;
  localparam int DEPTH  = seel_pkg::RING_DEPTH;
  localparam int DCOUNT = seel_pkg::DOMAIN_COUNT;

  // domain table
  logic [DCOUNT-1:0] seen;
  logic [3:0]        last_level [DCOUNT];

  // ring memory
  seel_pkg::entry_t  ring_mem [DEPTH];
  seel_pkg::entry_t  ring_rdata;
  logic              ring_we;
  logic              ring_re;
  logic [AW-1:0]     ring_waddr;
  logic [AW-1:0]     ring_raddr;
  seel_pkg::entry_t  ring_wdata;

  // log pointers and counts
  logic [AW-1:0]     write_slot, write_slot_next;
  logic [CW-1:0]     held_count, held_count_next;
  logic [31:0]       event_total, event_total_next;

  // holding stage
  logic              b_valid;
  logic              b_edge;
  logic              b_entry;
  logic [CW-1:0]     b_held;
  logic [31:0]       b_total;

  logic              in_fire;
  logic              move;
  logic              dom_ok;
  logic [DW-1:0]     didx;
  logic              dom_seen;
  logic [3:0]        dom_level;
  logic              is_edge;
  logic              is_base;
  logic              do_clear;
  logic              rd_entry;
  logic [PW-1:0]     pos_wide;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     oldest;
  logic [CW-1:0]     ws_ext;
  logic [AW:0]       slot_sum;

  assign move     = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || move;
  assign in_fire  = in_valid && in_ready;

  assign dom_ok    = {1'b0, in_data.domain} < seel_pkg::DOM_LIMIT;
  assign didx      = DW'(in_data.domain);
  assign dom_seen  = dom_ok && seen[didx];
  assign dom_level = dom_ok ? last_level[didx] : seel_pkg::SEV_NONE;

  // read address: oldest retained entry plus clamped position
  assign ws_ext = CW'(write_slot);
  always_comb begin
    if (PW'(in_data.read_index) >= PW'(held_count)) begin
      pos_wide = PW'(held_count) - PW'(1);
    end else begin
      pos_wide = PW'(in_data.read_index);
    end
    pos = AW'(pos_wide);
    if (ws_ext >= held_count) begin
      oldest = AW'(ws_ext - held_count);
    end else begin
      oldest = AW'(CW'(DEPTH) - held_count + ws_ext);
    end
    slot_sum = (AW+1)'(oldest) + (AW+1)'(pos);
    if (slot_sum >= (AW+1)'(DEPTH)) begin
      ring_raddr = AW'(slot_sum - (AW+1)'(DEPTH));
    end else begin
      ring_raddr = AW'(slot_sum);
    end
  end

  always_comb begin
    is_edge  = 1'b0;
    is_base  = 1'b0;
    do_clear = 1'b0;
    rd_entry = 1'b0;
    unique case (in_data.opcode)
      seel_pkg::OP_UPDATE: begin
        is_base = dom_ok && !dom_seen;
        is_edge = dom_seen && (in_data.severity != dom_level);
      end
      seel_pkg::OP_READ: begin
        rd_entry = held_count != '0;
      end
      seel_pkg::OP_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ring_we    = in_fire && is_edge;
  assign ring_re    = in_fire && rd_entry;
  assign ring_waddr = write_slot;
  assign ring_wdata = '{time_sec:   in_data.time_sec,
                        domain:     in_data.domain,
                        from_level: dom_level,
                        to_level:   in_data.severity};

  always_comb begin
    write_slot_next  = write_slot;
    held_count_next  = held_count;
    event_total_next = event_total;
    if (do_clear) begin
      write_slot_next  = '0;
      held_count_next  = '0;
      event_total_next = '0;
    end else if (is_edge) begin
      write_slot_next  = (write_slot == AW'(DEPTH - 1)) ? '0 : write_slot + AW'(1);
      held_count_next  = (held_count == CW'(DEPTH)) ? held_count : held_count + CW'(1);
      event_total_next = event_total + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= '0;
      write_slot  <= '0;
      held_count  <= '0;
      event_total <= '0;
    end else if (in_fire) begin
      write_slot  <= write_slot_next;
      held_count  <= held_count_next;
      event_total <= event_total_next;
      if (do_clear) begin
        seen <= '0;
      end else if (is_base) begin
        seen[didx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (is_base || is_edge)) begin
      last_level[didx] <= in_data.severity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_edge  <= is_edge;
      b_entry <= rd_entry;
      b_held  <= held_count_next;
      b_total <= event_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data.edge_recorded  <= b_edge;
      out_data.entry_valid    <= b_entry;
      out_data.event_time     <= b_entry ? ring_rdata.time_sec : 32'd0;
      out_data.event_domain   <= b_entry ? ring_rdata.domain[2:0] : 3'd0;
      out_data.event_from     <= b_entry ? ring_rdata.from_level : 4'd0;
      out_data.event_to       <= b_entry ? ring_rdata.to_level : 4'd0;
      out_data.retained_count <= seel_pkg::retained_t'(b_held);
      out_data.total_events   <= b_total;
    end
  end

endmodule

@@ rtl/core/seel_checker.sv @@
`timescale 1ns / 1ps

module seel_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input seel_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_ready,
  input seel_pkg::out_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.retained_count <= seel_pkg::retained_t'(seel_pkg::RING_DEPTH))
    else $error("retained count above ring depth");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.edge_recorded && out_data.entry_valid))
    else $error("beat reports both a recorded change and a read entry");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |->
      out_data.event_time == 32'd0 && out_data.event_domain == 3'd0 &&
      out_data.event_from == 4'd0 && out_data.event_to == 4'd0)
    else $error("event fields set without a read entry");

endmodule

bind severity_edge_event_log seel_checker u_seel_checker (.*);
